// ----- hdl/esc_ps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_ps_pkg
// Shared types and constants for the four-channel ESC pulse sequencer.
// ----------------------------------------------------------------------------
package esc_ps_pkg;

  localparam int NUM_MOTORS = 4;

  typedef logic [7:0] speed_t;
  typedef logic [8:0] width_t;
  typedef logic [9:0] period_t;
  typedef logic [1:0] slot_t;
  typedef logic [NUM_MOTORS-1:0] pins_t;

  localparam period_t GAP_RELOAD_RESET  = 10'd249;
  localparam period_t IDLE_RELOAD_RESET = 10'd499;

  typedef enum logic [0:0] {
    CFG_GAP_RELOAD  = 1'b0,
    CFG_IDLE_RELOAD = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    FUNC_TICK = 1'b0,
    FUNC_SET  = 1'b1
  } func_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    width_t width;
    speed_t readback;
  } lane_out_t;

  typedef struct packed {
    pins_t                       pins;
    slot_t                       slot;
    logic [NUM_MOTORS-1:0][7:0]  readback;
  } result_t;

endpackage

// ----- hdl/esc_ps_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_ps_lane
// One motor lane: turns an 8-bit speed into a pulse width and the speed
// recovered from that width, in three registered steps.
// ----------------------------------------------------------------------------
module esc_ps_lane #(
  parameter int PULSE_MIN_COUNT = 125
) (
  input  logic                  clk,
  input  logic                  en,
  input  esc_ps_pkg::speed_t    speed,
  output esc_ps_pkg::lane_out_t lane_out
);
  import esc_ps_pkg::*;

  localparam int PROD_W  = 16;
  localparam int RECIP_W = PROD_W + 1;
  localparam int MUL_W   = PROD_W + RECIP_W;

  // exact reciprocals for any dividend below 2**PROD_W
  localparam int DIV255_SHIFT = PROD_W + 8;
  localparam longint unsigned DIV255_RECIP =
    ((64'd1 << DIV255_SHIFT) + 64'd254) / 64'd255;
  localparam int RB_SHIFT = PROD_W + $clog2(PULSE_MIN_COUNT);
  localparam longint unsigned RB_RECIP =
    ((64'd1 << RB_SHIFT) + 64'(PULSE_MIN_COUNT) - 64'd1) / 64'(PULSE_MIN_COUNT);

  localparam logic [7:0]         MIN_K    = 8'(PULSE_MIN_COUNT);
  localparam logic [RECIP_W-1:0] DIV255_K = RECIP_W'(DIV255_RECIP);
  localparam logic [RECIP_W-1:0] RB_K     = RECIP_W'(RB_RECIP);

  logic [PROD_W-1:0] prod_r;
  logic              zero1_r;
  logic [7:0]        quot_r;
  logic              zero2_r;
  width_t            width_r;
  speed_t            readback_r;

  logic [MUL_W-1:0]  div255_full;
  logic [PROD_W-1:0] scaled;
  logic [MUL_W-1:0]  rb_full;

  always_comb begin
    div255_full = MUL_W'(prod_r) * MUL_W'(DIV255_K);
    // quotient times 255
    scaled      = {quot_r, 8'b0} - PROD_W'(quot_r);
    rb_full     = MUL_W'(scaled) * MUL_W'(RB_K);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r     <= PROD_W'(MIN_K) * PROD_W'(speed);
      zero1_r    <= (speed == 8'd0);
      quot_r     <= 8'(div255_full >> DIV255_SHIFT);
      zero2_r    <= zero1_r;
      width_r    <= zero2_r ? 9'd0 : (9'(quot_r) + 9'(MIN_K));
      readback_r <= 8'(rb_full >> RB_SHIFT);
    end
  end

  assign lane_out.width    = width_r;
  assign lane_out.readback = readback_r;

endmodule

// ----- hdl/esc_ps_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_ps_merge
// Merge stage: keeps the stored widths, the slot timer and the pin state,
// applies one transaction per push and forms its result.
// ----------------------------------------------------------------------------
module esc_ps_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  esc_ps_pkg::func_t     func,
  input  esc_ps_pkg::lane_out_t lanes [esc_ps_pkg::NUM_MOTORS],
  input  esc_ps_pkg::period_t   gap_reload,
  input  esc_ps_pkg::period_t   idle_reload,
  output esc_ps_pkg::result_t   result
);
  import esc_ps_pkg::*;

  width_t  widths_r   [NUM_MOTORS];
  width_t  widths_nxt [NUM_MOTORS];
  speed_t  rb_r       [NUM_MOTORS];
  speed_t  rb_nxt     [NUM_MOTORS];
  slot_t   slot_r, slot_nxt;
  logic    pin_r, pin_nxt;
  period_t tick_r, tick_nxt;
  period_t period_r, period_nxt;

  always_comb begin
    widths_nxt = widths_r;
    rb_nxt     = rb_r;
    slot_nxt   = slot_r;
    pin_nxt    = pin_r;
    tick_nxt   = tick_r;
    period_nxt = period_r;
    if (push) begin
      if (func == FUNC_SET) begin
        for (int i = 0; i < NUM_MOTORS; i++) begin
          widths_nxt[i] = lanes[i].width;
          rb_nxt[i]     = lanes[i].readback;
        end
      end else if (tick_r >= period_r) begin
        tick_nxt = '0;
        if (pin_r) begin
          pin_nxt    = 1'b0;
          period_nxt = gap_reload;
          slot_nxt   = slot_r + 2'd1;
        end else if (widths_r[slot_r] != '0) begin
          pin_nxt    = 1'b1;
          period_nxt = 10'(widths_r[slot_r]);
        end else begin
          period_nxt = idle_reload;
          slot_nxt   = slot_r + 2'd1;
        end
      end else begin
        tick_nxt = tick_r + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        widths_r[i] <= '0;
        rb_r[i]     <= '0;
      end
      slot_r   <= '0;
      pin_r    <= 1'b0;
      tick_r   <= '0;
      period_r <= GAP_RELOAD_RESET;
    end else begin
      widths_r <= widths_nxt;
      rb_r     <= rb_nxt;
      slot_r   <= slot_nxt;
      pin_r    <= pin_nxt;
      tick_r   <= tick_nxt;
      period_r <= period_nxt;
    end
  end

  always_comb begin
    result.pins = pin_nxt ? (pins_t'(1) << slot_nxt) : '0;
    result.slot = slot_nxt;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      result.readback[i] = rb_nxt[i];
    end
  end

endmodule

// ----- hdl/esc_pulse_sequencer_four_channel_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pulse_sequencer_four_channel_top
// Four-channel ESC pulse sequencer: timer-driven slot pulses per motor.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per item; in_func = tick advances the slot timer,
//           in_func = set loads four speeds (0 = motor off).
//   out_* : exactly one result per input transaction, in order: pin levels,
//           running slot and the four speeds read back from stored widths.
//   cfg_* : writes gap_reload (index 0) or idle_reload (index 1); always
//           ready, write only while no transaction is in flight.
//   Path: a result passes through the three lane stages, then the merge
//   stage writes the output register.
//   Throughput: one transaction per cycle when not stalled; the four lanes
//   work in parallel and the merge stage updates timer and pin state per push.
//   Stall: an output register plus one skid entry; in_ready depends only on
//   the skid entry, so the pipeline freezes while a result waits there, and
//   no result is lost.
//   Reset: widths zero, slot 0, pin low, timer 0, period 249, gap 249,
//   idle 499; the pipeline and output buffer are emptied.
// ----------------------------------------------------------------------------
module esc_pulse_sequencer_four_channel_top #(
  parameter int PULSE_MIN_COUNT = 125
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  esc_ps_pkg::cfg_idx_t cfg_index,
  input  esc_ps_pkg::period_t  cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  esc_ps_pkg::speed_t   in_speed_front_right,
  input  esc_ps_pkg::speed_t   in_speed_front_left,
  input  esc_ps_pkg::speed_t   in_speed_back_right,
  input  esc_ps_pkg::speed_t   in_speed_back_left,
  output logic                 out_valid,
  input  logic                 out_ready,
  output esc_ps_pkg::pins_t    out_pin_levels,
  output esc_ps_pkg::slot_t    out_active_slot,
  output esc_ps_pkg::speed_t   out_readback_front_right,
  output esc_ps_pkg::speed_t   out_readback_front_left,
  output esc_ps_pkg::speed_t   out_readback_back_right,
  output esc_ps_pkg::speed_t   out_readback_back_left
);
  import esc_ps_pkg::*;

  localparam int STAGES = 3;

  period_t gap_r, gap_nxt;
  period_t idle_r, idle_nxt;

  logic      en;
  logic      push;
  logic      pop;
  logic      vld_r  [STAGES];
  func_t     func_r [STAGES];
  speed_t    lane_speed [NUM_MOTORS];
  lane_out_t lane_res   [NUM_MOTORS];
  result_t   merge_res;

  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    gap_nxt  = gap_r;
    idle_nxt = idle_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GAP_RELOAD:  gap_nxt  = cfg_data;
        CFG_IDLE_RELOAD: idle_nxt = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r  <= GAP_RELOAD_RESET;
      idle_r <= IDLE_RELOAD_RESET;
    end else begin
      gap_r  <= gap_nxt;
      idle_r <= idle_nxt;
    end
  end

  // pipeline moves whenever the skid entry is free
  assign en       = !skid_valid_r;
  assign in_ready = en;
  assign push     = en && vld_r[STAGES-1];
  assign pop      = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STAGES; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < STAGES; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func_r[0] <= func_t'(in_func);
      for (int s = 1; s < STAGES; s++) begin
        func_r[s] <= func_r[s-1];
      end
    end
  end

  assign lane_speed[0] = in_speed_front_right;
  assign lane_speed[1] = in_speed_front_left;
  assign lane_speed[2] = in_speed_back_right;
  assign lane_speed[3] = in_speed_back_left;

  for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_lane
    esc_ps_lane #(
      .PULSE_MIN_COUNT(PULSE_MIN_COUNT)
    ) u_lane (
      .clk     (clk),
      .en      (en),
      .speed   (lane_speed[g]),
      .lane_out(lane_res[g])
    );
  end

  esc_ps_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .func       (func_r[STAGES-1]),
    .lanes      (lane_res),
    .gap_reload (gap_r),
    .idle_reload(idle_r),
    .result     (merge_res)
  );

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_data_r <= merge_res;
      end else begin
        out_data_r <= merge_res;
      end
    end
  end

  assign out_valid                = out_valid_r;
  assign out_pin_levels           = out_data_r.pins;
  assign out_active_slot          = out_data_r.slot;
  assign out_readback_front_right = out_data_r.readback[0];
  assign out_readback_front_left  = out_data_r.readback[1];
  assign out_readback_back_right  = out_data_r.readback[2];
  assign out_readback_back_left   = out_data_r.readback[3];

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-channel ESC pulse sequencer. A short
// table of directed transactions is followed by random phases under several
// gap/idle reload settings. Typed table rows carry their expected results;
// an in-bench model of the slot timer predicts the rest, and the results
// are checked in order. The sender works in bursts, and the receiver stalls
// on a pattern of its own, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import esc_ps_pkg::*;

  localparam int unsigned PULSE_MIN = 125;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 210;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    func_t                func;
    logic [3:0][7:0]      speed;
  } motor_cmd_t;

  typedef struct packed {
    motor_cmd_t cmd;
    logic       typed;
    result_t    result;
  } dir_row_t;

  logic    clk;
  logic    rst_n;
  logic    cfg_valid;
  logic    cfg_ready;
  cfg_idx_t cfg_index;
  period_t cfg_data;
  logic    in_valid;
  logic    in_ready;
  logic    in_func;
  speed_t  in_speed_front_right;
  speed_t  in_speed_front_left;
  speed_t  in_speed_back_right;
  speed_t  in_speed_back_left;
  logic    out_valid;
  logic    out_ready = 1'b0;
  pins_t   out_pin_levels;
  slot_t   out_active_slot;
  speed_t  out_readback_front_right;
  speed_t  out_readback_front_left;
  speed_t  out_readback_back_right;
  speed_t  out_readback_back_left;

  esc_pulse_sequencer_four_channel_top #(
    .PULSE_MIN_COUNT(PULSE_MIN)
  ) dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_func                  (in_func),
    .in_speed_front_right     (in_speed_front_right),
    .in_speed_front_left      (in_speed_front_left),
    .in_speed_back_right      (in_speed_back_right),
    .in_speed_back_left       (in_speed_back_left),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_pin_levels           (out_pin_levels),
    .out_active_slot          (out_active_slot),
    .out_readback_front_right (out_readback_front_right),
    .out_readback_front_left  (out_readback_front_left),
    .out_readback_back_right  (out_readback_back_right),
    .out_readback_back_left   (out_readback_back_left)
  );

  // sequencer model state
  width_t  width_q [NUM_MOTORS];
  slot_t   slot_q;
  bit      pin_q;
  period_t ticks_q;
  period_t period_q;
  period_t gap_q;
  period_t idle_q;

  result_t pending_results [$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      burst_left;
  logic    hold_trigger;
  bit      hold_used;
  int      hold_left;
  int      rx_left;
  int      rx_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic width_t speed_to_width(speed_t v);
    int unsigned t;
    if (v == 0) begin
      return '0;
    end
    t = (PULSE_MIN * 32'(v)) / 255 + PULSE_MIN;
    return width_t'(t);
  endfunction

  function automatic speed_t width_to_speed(width_t w);
    int unsigned t;
    if (w == 0) begin
      return '0;
    end
    t = 32'(w);
    t = ((t - PULSE_MIN) * 255) / PULSE_MIN;
    return speed_t'(t);
  endfunction

  function automatic result_t advance_sequencer(motor_cmd_t c);
    result_t r;
    if (c.func == FUNC_SET) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        width_q[i] = speed_to_width(c.speed[i]);
      end
    end else if (ticks_q >= period_q) begin
      ticks_q = '0;
      if (pin_q) begin
        pin_q = 1'b0;
        period_q = gap_q;
        slot_q = slot_q + 2'd1;
      end else if (width_q[slot_q] != 0) begin
        pin_q = 1'b1;
        period_q = period_t'(width_q[slot_q]);
      end else begin
        period_q = idle_q;
        slot_q = slot_q + 2'd1;
      end
    end else begin
      ticks_q = ticks_q + 10'd1;
    end
    r.pins = pin_q ? pins_t'(1 << slot_q) : '0;
    r.slot = slot_q;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      r.readback[i] = width_to_speed(width_q[i]);
    end
    return r;
  endfunction

  function automatic dir_row_t drow(func_t f, speed_t s0, speed_t s1, speed_t s2, speed_t s3,
                                    logic typed, pins_t p, slot_t sl, speed_t rb);
    dir_row_t d;
    d.cmd.func = f;
    d.cmd.speed = {s3, s2, s1, s0};
    d.typed = typed;
    d.result.pins = p;
    d.result.slot = sl;
    d.result.readback = {rb, rb, rb, rb};
    return d;
  endfunction

  function automatic speed_t rand_speed();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1: return 8'd0;
      2: return 8'd255;
      3: return 8'd1;
      default: return speed_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic motor_cmd_t rand_cmd();
    motor_cmd_t c;
    c.func = ($urandom_range(0, 99) < 12) ? FUNC_SET : FUNC_TICK;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      c.speed[i] = rand_speed();
    end
    return c;
  endfunction

  task automatic send_cmd(motor_cmd_t c, logic typed, result_t typed_result);
    result_t r;
    in_valid <= 1'b1;
    in_func <= c.func;
    in_speed_front_right <= c.speed[0];
    in_speed_front_left <= c.speed[1];
    in_speed_back_right <= c.speed[2];
    in_speed_back_left <= c.speed[3];
    do @(posedge clk); while (!in_ready);
    r = advance_sequencer(c);
    pending_results.push_back(typed ? typed_result : r);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 60);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_reloads(period_t gap, period_t idle);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_GAP_RELOAD;
    cfg_data <= gap;
    do @(posedge clk); while (!cfg_ready);
    gap_q = gap;
    cfg_index <= CFG_IDLE_RELOAD;
    cfg_data <= idle;
    do @(posedge clk); while (!cfg_ready);
    idle_q = idle;
    cfg_valid <= 1'b0;
  endtask

  // receiver: random ready pattern, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_used <= 1'b0;
      hold_left <= 0;
      rx_left <= 0;
      rx_mode <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_trigger && !hold_used) begin
      out_ready <= 1'b0;
      hold_used <= 1'b1;
      hold_left <= 300;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_left <= $urandom_range(8, 80);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.pins = out_pin_levels;
      got.slot = out_active_slot;
      got.readback = {out_readback_back_left, out_readback_back_right,
                      out_readback_front_left, out_readback_front_right};
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected transaction: pins %h slot %0d", got.pins, got.slot);
        end
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.pins !== want.pins || got.slot !== want.slot ||
            got.readback[0] !== want.readback[0] || got.readback[1] !== want.readback[1] ||
            got.readback[2] !== want.readback[2] || got.readback[3] !== want.readback[3]) begin
          if (mismatch_count < 10) begin
            $display("mismatch at %0t: pins exp %h got %h, slot exp %0d got %0d", $realtime,
                     want.pins, got.pins, want.slot, got.slot);
            $display("  readback exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                     want.readback[0], want.readback[1], want.readback[2], want.readback[3],
                     got.readback[0], got.readback[1], got.readback[2], got.readback[3]);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    dir_row_t rows [$];
    result_t  none;
    period_t  gap_set [NUM_PHASES];
    period_t  idle_set [NUM_PHASES];
    in_valid = 1'b0;
    in_func = FUNC_TICK;
    in_speed_front_right = '0;
    in_speed_front_left = '0;
    in_speed_back_right = '0;
    in_speed_back_left = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GAP_RELOAD;
    cfg_data = '0;
    hold_trigger = 1'b0;
    burst_left = 1;
    none = '0;
    rst_n = 1'b0;

    for (int i = 0; i < NUM_MOTORS; i++) begin
      width_q[i] = '0;
    end
    slot_q = '0;
    pin_q = 1'b0;
    ticks_q = '0;
    period_q = GAP_RELOAD_RESET;
    gap_q = GAP_RELOAD_RESET;
    idle_q = IDLE_RELOAD_RESET;

    // typed rows: reset state, speed field extremes, speed fields ignored on tick
    rows.push_back(drow(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 4'h0, 2'd0, 8'd0));
    rows.push_back(drow(FUNC_TICK, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 4'h0, 2'd0, 8'd0));
    rows.push_back(drow(FUNC_SET, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 4'h0, 2'd0, 8'd255));
    rows.push_back(drow(FUNC_SET, 8'd1, 8'd1, 8'd1, 8'd1, 1'b1, 4'h0, 2'd0, 8'd0));
    rows.push_back(drow(FUNC_TICK, 8'd200, 8'd17, 8'd99, 8'd3, 1'b1, 4'h0, 2'd0, 8'd0));
    rows.push_back(drow(FUNC_SET, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 4'h0, 2'd0, 8'd0));
    rows.push_back(drow(FUNC_SET, 8'd255, 8'd1, 8'd0, 8'd128, 1'b0, 4'h0, 2'd0, 8'd0));
    rows.push_back(drow(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 4'h0, 2'd0, 8'd0));
    rows.push_back(drow(FUNC_SET, 8'h55, 8'hAA, 8'h0F, 8'hF0, 1'b0, 4'h0, 2'd0, 8'd0));
    rows.push_back(drow(FUNC_SET, 8'hAA, 8'h55, 8'hF0, 8'h0F, 1'b0, 4'h0, 2'd0, 8'd0));
    rows.push_back(drow(FUNC_TICK, 8'h80, 8'h40, 8'h20, 8'h10, 1'b0, 4'h0, 2'd0, 8'd0));
    rows.push_back(drow(FUNC_SET, 8'd2, 8'd254, 8'd127, 8'd200, 1'b0, 4'h0, 2'd0, 8'd0));
    rows.push_back(drow(FUNC_SET, 8'd128, 8'd64, 8'd32, 8'd16, 1'b0, 4'h0, 2'd0, 8'd0));
    rows.push_back(drow(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 4'h0, 2'd0, 8'd0));

    // first phase keeps the reset reloads; a zero reload ends every period at once
    gap_set = '{GAP_RELOAD_RESET, 10'd1, 10'd0, 10'd1023, 10'd7, 10'd0};
    idle_set = '{IDLE_RELOAD_RESET, 10'd1, 10'd0, 10'd1023, 10'd3, 10'd0};
    gap_set[5] = period_t'($urandom_range(1, 40));
    idle_set[5] = period_t'($urandom_range(1, 40));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_cmd(rows[i].cmd, rows[i].typed, rows[i].result);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        drain();
        load_reloads(gap_set[p], idle_set[p]);
      end
      // long receiver hold-off while the sender keeps pushing
      if (p == 1) begin
        hold_trigger <= 1'b1;
      end
      repeat (PHASE_ITEMS) send_cmd(rand_cmd(), 1'b0, none);
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/esc_ps_pkg.sv
hdl/esc_ps_lane.sv
hdl/esc_ps_merge.sv
hdl/esc_pulse_sequencer_four_channel_top.sv
test/tb_top.sv
